[rtl/i2cbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_START         = 3'd1,
    PH_ADDR          = 3'd2,
    PH_DATA          = 3'd3,
    PH_STOP          = 3'd4,
    PH_FIN_ACK       = 3'd5,
    PH_FIN_STOP_NACK = 3'd6,
    PH_FIN_NACK      = 3'd7
  } phase_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    kind_e      kind;
    logic       scl_in;
    logic       sda_in;
    logic [7:0] byte_value;
    logic [6:0] target_addr;
    logic [7:0] length;
    logic       repeat_flag;
  } item_t;

  typedef struct packed {
    logic [1:0] accept_status;
    logic [1:0] transfer_status;
    logic       scl_low;
    logic       sda_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
  } result_t;

  typedef struct packed {
    logic [7:0] step_divide;
    logic       poll_always;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/i2cbs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/i2cbs_prescale.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_prescale (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick,
  input  wire i2cbs_pkg::cfg_t  cfg,
  output logic                  step
);

  logic [7:0] prescale_count;
  logic [7:0] prescale_count_next;
  logic       step_pending;
  logic       step_pending_next;
  logic [7:0] count_inc;
  logic       terminal;

  // divide of zero compares as always reached, same as one
  assign count_inc           = prescale_count + 8'd1;
  assign terminal            = (count_inc >= cfg.step_divide);
  assign prescale_count_next = terminal ? 8'd0 : count_inc;
  assign step                = step_pending | terminal;
  assign step_pending_next   = step & cfg.poll_always;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= 8'd0;
      step_pending   <= 1'b0;
    end else if (tick) begin
      prescale_count <= prescale_count_next;
      step_pending   <= step_pending_next;
    end
  end

endmodule

`default_nettype wire

[rtl/i2cbs_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_core #(
  parameter int TX_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               step,
  input  wire i2cbs_pkg::item_t   item,
  output i2cbs_pkg::result_t      result
);

  localparam int CW = $clog2(TX_DEPTH + 1);
  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TX_DEPTH);

  // byte engine outcome
  localparam logic [1:0] R_BUSY = 2'd0;
  localparam logic [1:0] R_ACK  = 2'd1;
  localparam logic [1:0] R_NACK = 2'd2;

  i2cbs_pkg::phase_e phase, phase_next;
  logic          rd_mode, rd_mode_next;
  logic [2:0]    start_step, start_step_next;
  logic [1:0]    stop_step, stop_step_next;
  logic [3:0]    byte_step, byte_step_next;
  logic [2:0]    bit_step, bit_step_next;
  logic [7:0]    shift_reg, shift_reg_next;
  logic          sampled_bit, sampled_bit_next;
  logic [7:0]    pending_byte, pending_byte_next;
  logic [6:0]    slave_addr, slave_addr_next;
  logic          no_stop, no_stop_next;
  logic [CW-1:0] write_total, write_total_next;
  logic [CW-1:0] write_pos, write_pos_next;
  logic [7:0]    read_total, read_total_next;
  logic [8:0]    read_pos, read_pos_next;
  logic [CW-1:0] push_count, push_count_next;
  logic [1:0]    status_reg, status_reg_next;
  logic          scl_drv, scl_drv_next;
  logic          sda_drv, sda_drv_next;

  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [1:0]    acc;
  logic          emit_valid;
  logic [7:0]    emit_byte;
  logic [7:0]    emit_index;

  // tx buffer; read port follows write_pos so the next byte is ready early
  i2cbs_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (ram_we & en),
    .waddr (push_count[AW-1:0]),
    .wdata (item.byte_value),
    .raddr (write_pos[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic       op_out;
    logic       op_in;
    logic       out_b;
    logic       b_done;
    logic       b_val;
    logic       is_rx;
    logic       nack;
    logic       start_done;
    logic       stop_done;
    logic [1:0] r;
    logic [7:0] d;

    phase_next        = phase;
    rd_mode_next      = rd_mode;
    start_step_next   = start_step;
    stop_step_next    = stop_step;
    byte_step_next    = byte_step;
    bit_step_next     = bit_step;
    shift_reg_next    = shift_reg;
    sampled_bit_next  = sampled_bit;
    pending_byte_next = pending_byte;
    slave_addr_next   = slave_addr;
    no_stop_next      = no_stop;
    write_total_next  = write_total;
    write_pos_next    = write_pos;
    read_total_next   = read_total;
    read_pos_next     = read_pos;
    push_count_next   = push_count;
    status_reg_next   = status_reg;
    scl_drv_next      = scl_drv;
    sda_drv_next      = sda_drv;
    ram_we            = 1'b0;
    acc               = i2cbs_pkg::ST_ERR;
    emit_valid        = 1'b0;
    emit_byte         = 8'd0;
    emit_index        = 8'd0;
    op_out            = 1'b0;
    op_in             = 1'b0;
    out_b             = 1'b0;
    b_done            = 1'b0;
    b_val             = 1'b0;
    start_done        = 1'b0;
    stop_done         = 1'b0;
    r                 = R_BUSY;
    is_rx             = rd_mode && (phase == i2cbs_pkg::PH_DATA);
    nack              = (read_total != 8'd0) &&
                        ((10'(read_pos) + 10'd1) >= 10'(read_total));
    d                 = (phase == i2cbs_pkg::PH_ADDR) ? {slave_addr, rd_mode} : pending_byte;

    case (item.kind)
      i2cbs_pkg::KIND_TICK: begin
        if (step) begin
          // byte level: pick the bit operation for this step
          if (phase == i2cbs_pkg::PH_ADDR || phase == i2cbs_pkg::PH_DATA) begin
            if (is_rx) begin
              if (byte_step == 4'd0) begin
                shift_reg_next = 8'd0;
                sda_drv_next   = 1'b0;
                bit_step_next  = 3'd0;
                byte_step_next = 4'd2;
              end else if (byte_step >= 4'd2 && byte_step <= 4'd9) begin
                op_in = 1'b1;
              end else if (byte_step == 4'd10) begin
                op_out = 1'b1;
                out_b  = nack;
              end else begin
                r = R_NACK;
              end
            end else begin
              // first step of a byte loads it and starts bit one at once
              if (byte_step == 4'd0) begin
                bit_step_next  = 3'd0;
                shift_reg_next = d;
                byte_step_next = 4'd1;
              end
              if (byte_step_next >= 4'd1 && byte_step_next <= 4'd8) begin
                op_out = 1'b1;
                out_b  = shift_reg_next[7];
              end else if (byte_step_next == 4'd9) begin
                op_in = 1'b1;
              end else begin
                r = R_NACK;
              end
            end
          end

          // bit level
          if (op_out) begin
            case (bit_step_next)
              3'd0: begin
                sda_drv_next  = ~out_b;
                bit_step_next = 3'd1;
              end
              3'd1: begin
                scl_drv_next  = 1'b0;
                bit_step_next = 3'd2;
              end
              3'd2: begin
                if (item.scl_in) begin
                  bit_step_next = 3'd3;
                end
              end
              3'd3: begin
                scl_drv_next  = 1'b1;
                bit_step_next = 3'd4;
              end
              default: begin
                b_done = 1'b1;
              end
            endcase
          end
          if (op_in) begin
            case (bit_step_next)
              3'd0: begin
                sampled_bit_next = 1'b0;
                sda_drv_next     = 1'b0;
                bit_step_next    = 3'd1;
              end
              3'd1: begin
                scl_drv_next  = 1'b0;
                bit_step_next = 3'd2;
              end
              3'd2: begin
                if (item.scl_in) begin
                  bit_step_next = 3'd3;
                end
              end
              3'd3: begin
                sampled_bit_next = item.sda_in;
                scl_drv_next     = 1'b1;
                bit_step_next    = 3'd4;
              end
              3'd4: begin
                b_done = 1'b1;
                b_val  = sampled_bit_next;
              end
              default: begin
                b_done = 1'b1;
              end
            endcase
          end

          // finished bit: shift and count, or report the ack slot
          if (b_done) begin
            bit_step_next = 3'd0;
            if (is_rx) begin
              if (op_in) begin
                shift_reg_next = {shift_reg_next[6:0], b_val};
                byte_step_next = byte_step_next + 4'd1;
              end else begin
                r = R_ACK;
              end
            end else begin
              if (op_out) begin
                shift_reg_next = {shift_reg_next[6:0], 1'b0};
                byte_step_next = byte_step_next + 4'd1;
              end else begin
                r = b_val ? R_NACK : R_ACK;
              end
            end
          end

          // start pattern
          if (phase == i2cbs_pkg::PH_START) begin
            case (start_step)
              3'd0: begin
                sda_drv_next    = 1'b0;
                start_step_next = 3'd1;
              end
              3'd1: begin
                scl_drv_next    = 1'b0;
                start_step_next = 3'd2;
              end
              3'd2: begin
                sda_drv_next    = 1'b1;
                start_step_next = 3'd3;
              end
              3'd3: begin
                scl_drv_next    = 1'b1;
                start_step_next = 3'd4;
                start_done      = 1'b1;
              end
              default: begin
                start_done = 1'b1;
              end
            endcase
          end

          // stop pattern, skipped on repeated start
          if (phase == i2cbs_pkg::PH_STOP || phase == i2cbs_pkg::PH_FIN_STOP_NACK) begin
            if (no_stop) begin
              stop_done = 1'b1;
            end else begin
              case (stop_step)
                2'd0: begin
                  sda_drv_next   = 1'b1;
                  stop_step_next = 2'd1;
                end
                2'd1: begin
                  scl_drv_next   = 1'b0;
                  stop_step_next = 2'd2;
                end
                2'd2: begin
                  sda_drv_next   = 1'b0;
                  stop_step_next = 2'd3;
                  stop_done      = 1'b1;
                end
                default: begin
                  stop_done = 1'b1;
                end
              endcase
            end
          end

          // phase sequencing
          case (phase)
            i2cbs_pkg::PH_IDLE: begin
              status_reg_next = status_reg;
            end
            i2cbs_pkg::PH_START: begin
              status_reg_next = i2cbs_pkg::ST_BUSY;
              if (start_done) begin
                byte_step_next = 4'd0;
                phase_next     = i2cbs_pkg::PH_ADDR;
              end
            end
            i2cbs_pkg::PH_ADDR, i2cbs_pkg::PH_DATA: begin
              status_reg_next = i2cbs_pkg::ST_BUSY;
              if (r == R_NACK) begin
                phase_next = i2cbs_pkg::PH_FIN_STOP_NACK;
              end else if (r == R_ACK) begin
                if (rd_mode) begin
                  byte_step_next = 4'd0;
                  if (phase == i2cbs_pkg::PH_ADDR) begin
                    phase_next = i2cbs_pkg::PH_DATA;
                  end else begin
                    if (nack) begin
                      phase_next = i2cbs_pkg::PH_STOP;
                    end
                    if (read_pos < {1'b0, read_total}) begin
                      emit_valid = 1'b1;
                      emit_byte  = shift_reg_next;
                      emit_index = read_pos[7:0];
                    end else begin
                      // zero length read: byte taken but not presented
                      phase_next = i2cbs_pkg::PH_FIN_STOP_NACK;
                    end
                    read_pos_next = read_pos + 9'd1;
                  end
                end else if (write_pos < write_total) begin
                  byte_step_next    = 4'd0;
                  pending_byte_next = ram_rdata;
                  write_pos_next    = write_pos + CW'(1);
                  phase_next        = i2cbs_pkg::PH_DATA;
                end else if (phase == i2cbs_pkg::PH_ADDR) begin
                  // zero length write ends in error
                  phase_next = i2cbs_pkg::PH_FIN_STOP_NACK;
                end else begin
                  phase_next = i2cbs_pkg::PH_STOP;
                end
              end
            end
            i2cbs_pkg::PH_STOP: begin
              status_reg_next = i2cbs_pkg::ST_BUSY;
              if (stop_done) begin
                phase_next = i2cbs_pkg::PH_FIN_ACK;
              end
            end
            i2cbs_pkg::PH_FIN_ACK: begin
              status_reg_next = i2cbs_pkg::ST_OK;
              phase_next      = i2cbs_pkg::PH_IDLE;
            end
            i2cbs_pkg::PH_FIN_STOP_NACK: begin
              status_reg_next = i2cbs_pkg::ST_BUSY;
              if (stop_done) begin
                phase_next = i2cbs_pkg::PH_FIN_NACK;
              end
            end
            default: begin
              status_reg_next = i2cbs_pkg::ST_ERR;
              phase_next      = i2cbs_pkg::PH_IDLE;
            end
          endcase
        end
      end

      i2cbs_pkg::KIND_PUSH: begin
        // ignored while a write runs or when the buffer is full
        if ((phase == i2cbs_pkg::PH_IDLE || rd_mode) && push_count < DEPTH_C) begin
          ram_we          = 1'b1;
          push_count_next = push_count + CW'(1);
        end
      end

      default: begin
        if (item.kind == i2cbs_pkg::KIND_WRITE && {1'b0, item.length} > 9'(TX_DEPTH)) begin
          acc = i2cbs_pkg::ST_ERR;
        end else if (phase != i2cbs_pkg::PH_IDLE) begin
          acc = i2cbs_pkg::ST_BUSY;
        end else begin
          acc             = i2cbs_pkg::ST_OK;
          start_step_next = 3'd0;
          stop_step_next  = 2'd0;
          slave_addr_next = item.target_addr;
          status_reg_next = i2cbs_pkg::ST_BUSY;
          phase_next      = i2cbs_pkg::PH_START;
          if (item.kind == i2cbs_pkg::KIND_WRITE) begin
            rd_mode_next     = 1'b0;
            no_stop_next     = item.repeat_flag;
            write_total_next = CW'(item.length);
            write_pos_next   = '0;
            push_count_next  = '0;
          end else begin
            rd_mode_next    = 1'b1;
            read_total_next = item.length;
            read_pos_next   = 9'd0;
          end
        end
      end
    endcase
  end

  assign result.accept_status   = acc;
  assign result.transfer_status = status_reg_next;
  assign result.scl_low         = scl_drv_next;
  assign result.sda_low         = sda_drv_next;
  assign result.rx_valid        = emit_valid;
  assign result.rx_byte         = emit_byte;
  assign result.rx_index        = emit_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cbs_pkg::PH_IDLE;
      rd_mode    <= 1'b0;
      start_step <= 3'd0;
      stop_step  <= 2'd0;
      byte_step  <= 4'd0;
      bit_step   <= 3'd0;
      no_stop    <= 1'b0;
      write_pos  <= '0;
      read_pos   <= 9'd0;
      push_count <= '0;
      status_reg <= i2cbs_pkg::ST_ERR;
      scl_drv    <= 1'b0;
      sda_drv    <= 1'b0;
    end else if (en) begin
      phase      <= phase_next;
      rd_mode    <= rd_mode_next;
      start_step <= start_step_next;
      stop_step  <= stop_step_next;
      byte_step  <= byte_step_next;
      bit_step   <= bit_step_next;
      no_stop    <= no_stop_next;
      write_pos  <= write_pos_next;
      read_pos   <= read_pos_next;
      push_count <= push_count_next;
      status_reg <= status_reg_next;
      scl_drv    <= scl_drv_next;
      sda_drv    <= sda_drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shift_reg    <= shift_reg_next;
      sampled_bit  <= sampled_bit_next;
      pending_byte <= pending_byte_next;
      slave_addr   <= slave_addr_next;
      write_total  <= write_total_next;
      read_total   <= read_total_next;
    end
  end

endmodule

`default_nettype wire

[rtl/i2c_master_bit_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// I2C master bit sequencer, open-drain, one write or one read transaction at a time.
// Input channel (in_valid/in_ready) carries one request per item: a timer tick with
// the sampled SCL/SDA pins, a tx byte push, or a start-write / start-read command.
// Output channel (out_valid/out_ready) returns exactly one result per request: the
// command reply, transfer status, the SCL/SDA pull-down drives, and a received byte
// with its index when a read byte completes.
// Ticks are divided by step_divide (APB reg 0) into sequencer steps; poll_always
// (APB reg 1) keeps stepping on every tick after the first step.
// Path: a request accepted into the input register then passes the step logic into the
// result register. Throughput: one request per cycle while out_ready keeps the result
// register draining; the single step of the sequencer is all the work a request needs.
// Stall: while out_ready is low the result register holds, the input register still
// takes one more request, then in_ready drops until the result is taken.
// Reset (rst, synchronous): both lines released, sequencer idle, status error,
// step_divide 1, poll_always 0. The tx buffer RAM is not cleared.
// The tx buffer holds TX_DEPTH bytes; write lengths above it are refused.

module i2c_master_bit_sequencer #(
  parameter int TX_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic        scl_in,
  input  wire logic        sda_in,
  input  wire logic [7:0]  byte_value,
  input  wire logic [6:0]  target_addr,
  input  wire logic [7:0]  length,
  input  wire logic        repeat_flag,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  accept_status,
  output logic      [1:0]  transfer_status,
  output logic             scl_low,
  output logic             sda_low,
  output logic             rx_valid,
  output logic      [7:0]  rx_byte,
  output logic      [7:0]  rx_index
);

  localparam logic REG_STEP_DIVIDE = 1'b0;
  localparam logic REG_POLL_ALWAYS = 1'b1;

  i2cbs_pkg::cfg_t    cfg;
  i2cbs_pkg::item_t   in_item;
  i2cbs_pkg::item_t   s1_item;
  i2cbs_pkg::result_t core_res;
  i2cbs_pkg::result_t res;
  logic               s1_valid;
  logic               adv;
  logic               step;
  logic               cfg_wr;

  // ---------------- APB config registers ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_divide <= 8'd1;
      cfg.poll_always <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STEP_DIVIDE: cfg.step_divide <= pwdata[7:0];
        REG_POLL_ALWAYS: cfg.poll_always <= pwdata[0];
        default:         cfg.poll_always <= cfg.poll_always;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STEP_DIVIDE: prdata = {24'd0, cfg.step_divide};
      REG_POLL_ALWAYS: prdata = {31'd0, cfg.poll_always};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- input register ----------------
  assign in_item.kind        = i2cbs_pkg::kind_e'(kind);
  assign in_item.scl_in      = scl_in;
  assign in_item.sda_in      = sda_in;
  assign in_item.byte_value  = byte_value;
  assign in_item.target_addr = target_addr;
  assign in_item.length      = length;
  assign in_item.repeat_flag = repeat_flag;

  // request moves into the result register when that slot is free or draining
  assign adv      = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid & in_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      s1_item <= in_item;
    end
  end

  // ---------------- step logic ----------------
  i2cbs_prescale u_prescale (
    .clk  (clk),
    .rst  (rst),
    .tick (adv & (s1_item.kind == i2cbs_pkg::KIND_TICK)),
    .cfg  (cfg),
    .step (step)
  );

  i2cbs_core #(
    .TX_DEPTH (TX_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .step   (step),
    .item   (s1_item),
    .result (core_res)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= core_res;
    end
  end

  assign accept_status   = res.accept_status;
  assign transfer_status = res.transfer_status;
  assign scl_low         = res.scl_low;
  assign sda_low         = res.sda_low;
  assign rx_valid        = res.rx_valid;
  assign rx_byte         = res.rx_byte;
  assign rx_index        = res.rx_index;

  // ---------------- assertions ----------------
  // an empty result slot never back-pressures the request side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  // a received byte only comes from a tick during a running read
  a_rx_on_busy_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |->
      transfer_status == i2cbs_pkg::ST_BUSY && accept_status == i2cbs_pkg::ST_ERR)
    else $error("rx byte presented outside a busy read step");

  // an accepted command always leaves the transfer running
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && accept_status == i2cbs_pkg::ST_OK |->
      transfer_status == i2cbs_pkg::ST_BUSY)
    else $error("accepted command without busy status");

endmodule

`default_nettype wire

[tb/sv/tb_i2c_master_bit_sequencer.sv]
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer;
  import i2cbs_pkg::*;

  localparam int TX_SLOTS = 16;
  // APB map: one 32-bit word per register
  localparam logic [2:0] REG_STEP_DIVIDE = 3'd0;
  localparam logic [2:0] REG_POLL_ALWAYS = 3'd4;
  // cycles with no handshake on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // bound on requests spent chasing one transfer before the next session starts
  localparam int SESSION_TICKS = 300;
  localparam int N_PHASES = 7;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic        scl_in = 1'b0;
  logic        sda_in = 1'b0;
  logic [7:0]  byte_value = '0;
  logic [6:0]  target_addr = '0;
  logic [7:0]  length = '0;
  logic        repeat_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  accept_status;
  logic [1:0]  transfer_status;
  logic        scl_low;
  logic        sda_low;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic [7:0]  rx_index;

  i2c_master_bit_sequencer #(.TX_DEPTH(TX_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .scl_in(scl_in), .sda_in(sda_in), .byte_value(byte_value),
    .target_addr(target_addr), .length(length), .repeat_flag(repeat_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .accept_status(accept_status), .transfer_status(transfer_status),
    .scl_low(scl_low), .sda_low(sda_low),
    .rx_valid(rx_valid), .rx_byte(rx_byte), .rx_index(rx_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus-level model of the sequencer: config, prescaler, phases, bit counters
  // ---------------------------------------------------------------------------
  logic [7:0] div_q;
  logic       poll_q;
  logic [7:0] presc_q;
  logic       step_due;
  phase_e     wr_phase, rd_phase;
  logic [2:0] start_idx;
  logic [1:0] stop_idx;
  logic [3:0] byte_idx;
  logic [2:0] bit_idx;
  logic [7:0] shifter;
  logic       sampled;
  logic [7:0] next_tx;
  logic [6:0] addr_q;
  logic       hold_bus;       // repeated start: stop condition skipped
  logic [4:0] wr_len, wr_next;
  logic [7:0] rd_len;
  logic [8:0] rd_next;
  logic [7:0] tx_mem [TX_SLOTS];
  logic [4:0] tx_fill;
  logic [4:0] tx_fill_hi;     // entries ever written since reset
  logic [1:0] bus_status;
  logic       scl_dn, sda_dn;
  logic       pin_scl, pin_sda;
  logic       rx_v;
  logic [7:0] rx_b, rx_i;
  int         xfer_ok, xfer_err, rx_shown;

  function automatic int start_pattern();
    case (start_idx)
      3'd0: begin sda_dn = 1'b0; start_idx = 3'd1; return 0; end
      3'd1: begin scl_dn = 1'b0; start_idx = 3'd2; return 0; end
      3'd2: begin sda_dn = 1'b1; start_idx = 3'd3; return 0; end
      3'd3: begin scl_dn = 1'b1; start_idx = 3'd4; return 1; end
      default: return 1;
    endcase
  endfunction

  function automatic int stop_pattern();
    case (stop_idx)
      2'd0: begin sda_dn = 1'b1; stop_idx = 2'd1; return 0; end
      2'd1: begin scl_dn = 1'b0; stop_idx = 2'd2; return 0; end
      2'd2: begin sda_dn = 1'b0; stop_idx = 2'd3; return 1; end
      default: return 1;
    endcase
  endfunction

  function automatic int send_bit(logic b);
    case (bit_idx)
      3'd0: begin sda_dn = !b; bit_idx = 3'd1; return 0; end
      3'd1: begin scl_dn = 1'b0; bit_idx = 3'd2; return 0; end
      3'd2: begin if (pin_scl) bit_idx = 3'd3; return 0; end  // slave may stretch
      3'd3: begin scl_dn = 1'b1; bit_idx = 3'd4; return 0; end
      default: return 1;
    endcase
  endfunction

  // 0 busy, 1 + sampled bit when done
  function automatic int recv_bit();
    case (bit_idx)
      3'd0: begin sampled = 1'b0; sda_dn = 1'b0; bit_idx = 3'd1; return 0; end
      3'd1: begin scl_dn = 1'b0; bit_idx = 3'd2; return 0; end
      3'd2: begin if (pin_scl) bit_idx = 3'd3; return 0; end
      3'd3: begin sampled = pin_sda; scl_dn = 1'b1; bit_idx = 3'd4; return 0; end
      3'd4: return sampled ? 2 : 1;
      default: return 1;
    endcase
  endfunction

  // 0 busy, 1 slave ACK, 2 slave NACK
  function automatic int send_byte(logic [7:0] d);
    int r;
    if (byte_idx == 4'd0) begin
      bit_idx = 3'd0;
      shifter = d;
      byte_idx = 4'd1;
    end
    if (byte_idx >= 4'd1 && byte_idx <= 4'd8) begin
      if (send_bit(shifter[7]) != 0) begin
        shifter = {shifter[6:0], 1'b0};
        bit_idx = 3'd0;
        byte_idx++;
      end
      return 0;
    end
    if (byte_idx == 4'd9) begin
      r = recv_bit();
      if (r != 0) bit_idx = 3'd0;
      return r;
    end
    return 2;
  endfunction

  // 0 busy, 1 byte done, 2 fault
  function automatic int recv_byte(logic nack);
    int r;
    if (byte_idx == 4'd0) begin
      shifter = '0;
      sda_dn = 1'b0;
      bit_idx = 3'd0;
      byte_idx = 4'd2;
      return 0;
    end
    if (byte_idx >= 4'd2 && byte_idx <= 4'd9) begin
      r = recv_bit();
      if (r != 0) begin
        shifter = {shifter[6:0], (r == 2) ? 1'b1 : 1'b0};
        bit_idx = 3'd0;
        byte_idx++;
      end
      return 0;
    end
    if (byte_idx == 4'd10) begin
      if (send_bit(nack) != 0) begin
        bit_idx = 3'd0;
        return 1;
      end
      return 0;
    end
    return 2;
  endfunction

  // stop / completion phases common to both directions
  function automatic phase_e wind_down(phase_e ph);
    case (ph)
      PH_STOP: begin
        bus_status = ST_BUSY;
        if (hold_bus) return PH_FIN_ACK;
        if (stop_pattern() != 0) return PH_FIN_ACK;
        return ph;
      end
      PH_FIN_ACK: begin
        bus_status = ST_OK;
        xfer_ok++;
        return PH_IDLE;
      end
      PH_FIN_STOP_NACK: begin
        bus_status = ST_BUSY;
        if (hold_bus) return PH_FIN_NACK;
        if (stop_pattern() != 0) return PH_FIN_NACK;
        return ph;
      end
      default: begin
        bus_status = ST_ERR;
        xfer_err++;
        return PH_IDLE;
      end
    endcase
  endfunction

  function automatic void write_engine();
    int r;
    case (wr_phase)
      PH_IDLE: begin
        start_idx = '0;
        stop_idx = '0;
      end
      PH_START: begin
        if (start_pattern() != 0) begin
          byte_idx = '0;
          wr_phase = PH_ADDR;
        end
        bus_status = ST_BUSY;
      end
      PH_ADDR, PH_DATA: begin
        r = send_byte(wr_phase == PH_ADDR ? {addr_q, 1'b0} : next_tx);
        if (r == 2) begin
          wr_phase = PH_FIN_STOP_NACK;
        end else if (r == 1) begin
          if (wr_next < wr_len && wr_next < TX_SLOTS) begin
            byte_idx = '0;
            next_tx = tx_mem[wr_next];
            wr_next++;
            wr_phase = PH_DATA;
          end else begin
            // zero-length write: address only, then error; else the last byte ends in stop
            wr_phase = (wr_phase == PH_ADDR) ? PH_FIN_STOP_NACK : PH_STOP;
          end
        end
        bus_status = ST_BUSY;
      end
      default: wr_phase = wind_down(wr_phase);
    endcase
  endfunction

  function automatic void read_engine();
    int r;
    logic nack;
    case (rd_phase)
      PH_IDLE: begin
        start_idx = '0;
        stop_idx = '0;
      end
      PH_START: begin
        rd_next = '0;
        if (start_pattern() != 0) begin
          byte_idx = '0;
          rd_phase = PH_ADDR;
        end
        bus_status = ST_BUSY;
      end
      PH_ADDR: begin
        r = send_byte({addr_q, 1'b1});
        if (r == 2) rd_phase = PH_FIN_STOP_NACK;
        else if (r == 1) begin
          byte_idx = '0;
          rd_phase = PH_DATA;
        end
        bus_status = ST_BUSY;
      end
      PH_DATA: begin
        nack = (rd_len != 0) && ((int'(rd_next) + 1) >= int'(rd_len));
        r = recv_byte(nack);
        if (r == 2) begin
          rd_phase = PH_FIN_STOP_NACK;
        end else if (r == 1) begin
          byte_idx = '0;
          if (nack) rd_phase = PH_STOP;
          if (rd_next < rd_len) begin
            rx_v = 1'b1;
            rx_b = shifter;
            rx_i = rd_next[7:0];
            rx_shown++;
          end else begin
            // zero-length read: byte taken but not shown, ends in error
            rd_phase = PH_FIN_STOP_NACK;
          end
          rd_next++;
        end
        bus_status = ST_BUSY;
      end
      default: rd_phase = wind_down(rd_phase);
    endcase
  endfunction

  function automatic void seq_reset();
    div_q = 8'd1; poll_q = 1'b0;
    presc_q = '0; step_due = 1'b0;
    wr_phase = PH_IDLE; rd_phase = PH_IDLE;
    start_idx = '0; stop_idx = '0; byte_idx = '0; bit_idx = '0;
    shifter = '0; sampled = 1'b0; next_tx = '0; addr_q = '0; hold_bus = 1'b0;
    wr_len = '0; wr_next = '0; rd_len = '0; rd_next = '0;
    tx_fill = '0; tx_fill_hi = '0;
    bus_status = ST_ERR; scl_dn = 1'b0; sda_dn = 1'b0;
  endfunction

  function automatic logic seq_idle();
    return wr_phase == PH_IDLE && rd_phase == PH_IDLE;
  endfunction

  function automatic result_t seq_request(item_t it);
    result_t res;
    logic [1:0] reply;
    logic idle_now;
    reply = ST_ERR;
    idle_now = seq_idle();
    pin_scl = it.scl_in;
    pin_sda = it.sda_in;
    rx_v = 1'b0; rx_b = '0; rx_i = '0;
    case (it.kind)
      KIND_TICK: begin
        presc_q++;
        if (presc_q >= div_q) begin
          presc_q = '0;
          step_due = 1'b1;
        end
        if (step_due) begin
          if (!poll_q) step_due = 1'b0;
          if (rd_phase == PH_IDLE) write_engine();
          if (wr_phase == PH_IDLE) read_engine();
        end
      end
      KIND_PUSH: begin
        // dropped while full or while a write runs
        if (wr_phase == PH_IDLE && tx_fill < TX_SLOTS) begin
          tx_mem[tx_fill] = it.byte_value;
          tx_fill++;
          if (tx_fill > tx_fill_hi) tx_fill_hi = tx_fill;
        end
      end
      default: begin
        if (it.kind == KIND_WRITE && it.length > TX_SLOTS) begin
          reply = ST_ERR;
        end else if (!idle_now) begin
          reply = ST_BUSY;
        end else begin
          start_idx = '0;
          stop_idx = '0;
          addr_q = it.target_addr;
          bus_status = ST_BUSY;
          reply = ST_OK;
          if (it.kind == KIND_WRITE) begin
            hold_bus = it.repeat_flag;
            wr_len = it.length[4:0];
            wr_next = '0;
            tx_fill = '0;
            wr_phase = PH_START;
          end else begin
            // reads keep whatever stop choice the last write left
            rd_len = it.length;
            rd_next = '0;
            rd_phase = PH_START;
          end
        end
      end
    endcase
    res.accept_status = reply;
    res.transfer_status = bus_status;
    res.scl_low = scl_dn;
    res.sda_low = sda_dn;
    res.rx_valid = rx_v;
    res.rx_byte = rx_b;
    res.rx_index = rx_i;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  result_t expected_replies[$];
  int      send_idle_pct;
  int      stall_pct;
  logic    abort_xfer;       // slave NACKs the current transfer
  int      requests_sent;
  int      results_seen;
  int      mismatches;
  int      quiet_cycles;

  function automatic item_t random_item();
    item_t it;
    it.kind = kind_e'($urandom_range(3));
    it.scl_in = 1'($urandom_range(1));
    it.sda_in = 1'($urandom_range(1));
    it.byte_value = 8'($urandom_range(255));
    it.target_addr = 7'($urandom_range(127));
    it.length = 8'($urandom_range(255));
    it.repeat_flag = 1'($urandom_range(1));
    return it;
  endfunction

  // tick that looks like a cooperating slave: SCL mostly released, ACK at
  // the acknowledge sample unless this transfer is meant to be refused, with rare random NACKs
  function automatic item_t make_tick();
    item_t it;
    logic at_ack;
    it = random_item();
    it.kind = KIND_TICK;
    it.scl_in = ($urandom_range(99) >= 8);
    at_ack = byte_idx == 4'd9 && bit_idx == 3'd3 &&
             (rd_phase == PH_ADDR ||
              (rd_phase == PH_IDLE && (wr_phase == PH_ADDR || wr_phase == PH_DATA)));
    if (at_ack) it.sda_in = abort_xfer || ($urandom_range(99) < 3);
    return it;
  endfunction

  // drive one request, hold it until taken, then predict its result
  task automatic send_request(item_t it, logic typed = 1'b0, result_t typed_want = '0);
    logic taken;
    result_t want;
    // a write may only send tx entries that were filled since reset;
    // long reads are cut short by an address NACK
    if (seq_idle() && (it.kind == KIND_WRITE || it.kind == KIND_READ)) begin
      if (it.kind == KIND_WRITE && it.length <= TX_SLOTS && it.length > tx_fill_hi)
        it.length = {3'b000, tx_fill_hi};
      abort_xfer = (it.kind == KIND_READ && it.length > 6) || ($urandom_range(9) == 0);
    end
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    scl_in <= it.scl_in;
    sda_in <= it.sda_in;
    byte_value <= it.byte_value;
    target_addr <= it.target_addr;
    length <= it.length;
    repeat_flag <= it.repeat_flag;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
    want = seq_request(it);
    expected_replies.push_back(typed ? typed_want : want);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    logic done;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_STEP_DIVIDE) div_q = data[7:0];
    else if (addr == REG_POLL_ALWAYS) poll_q = data[0];
  endtask

  // pushes, one command, then ticks until the transfer settles
  task automatic run_session();
    item_t it;
    int n_ticks;
    repeat (($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4)) begin
      it = random_item();
      it.kind = KIND_PUSH;
      send_request(it);
    end
    if ($urandom_range(99) < 4) drain_results();
    it = random_item();
    it.kind = $urandom_range(1) ? KIND_WRITE : KIND_READ;
    case ($urandom_range(9))
      0: it.length = 8'd0;
      1: it.length = 8'($urandom_range(255));
      default: it.length = (it.kind == KIND_WRITE) ? 8'($urandom_range(1, TX_SLOTS))
                                                   : 8'($urandom_range(1, 4));
    endcase
    send_request(it);
    n_ticks = 0;
    while (!seq_idle() && n_ticks < SESSION_TICKS) begin
      // occasional noise: stray pushes, busy commands, random pin levels
      send_request(($urandom_range(19) == 0) ? random_item() : make_tick());
      n_ticks++;
    end
    repeat ($urandom_range(0, 3)) send_request(make_tick());
  endtask

  task automatic flag_mismatch(string field, logic [7:0] got, logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, checking and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // outputs are sampled mid-cycle; they only move at the rising edge
  always @(negedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{accept_status, transfer_status, scl_low, sda_low, rx_valid, rx_byte, rx_index};
        if (expected_replies.size() == 0) begin
          flag_mismatch("unexpected result", 8'd1, 8'd0);
        end else begin
          want = expected_replies.pop_front();
          if (got.accept_status !== want.accept_status)
            flag_mismatch("accept_status", got.accept_status, want.accept_status);
          if (got.transfer_status !== want.transfer_status)
            flag_mismatch("transfer_status", got.transfer_status, want.transfer_status);
          if (got.scl_low !== want.scl_low) flag_mismatch("scl_low", got.scl_low, want.scl_low);
          if (got.sda_low !== want.sda_low) flag_mismatch("sda_low", got.sda_low, want.sda_low);
          if (got.rx_valid !== want.rx_valid)
            flag_mismatch("rx_valid", got.rx_valid, want.rx_valid);
          if (got.rx_byte !== want.rx_byte) flag_mismatch("rx_byte", got.rx_byte, want.rx_byte);
          if (got.rx_index !== want.rx_index)
            flag_mismatch("rx_index", got.rx_index, want.rx_index);
        end
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_replies.size());
          $display("tb_i2c_master_bit_sequencer failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t   it;
    logic    typed;
    result_t want;
  } dir_row_t;

  function automatic dir_row_t mk_row(kind_e k, logic scl, logic sda, logic [7:0] bv,
                                      logic [6:0] ad, logic [7:0] len, logic rep,
                                      logic typed, logic [1:0] acc, logic [1:0] st);
    dir_row_t r;
    r.it = '{k, scl, sda, bv, ad, len, rep};
    r.typed = typed;
    r.want = '{acc, st, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00};
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    int ph_div [N_PHASES];
    int ph_poll [N_PHASES];
    int ph_send [N_PHASES];
    int ph_stall [N_PHASES];
    int ph_items [N_PHASES];
    int budget;

    // step divide covers 1, 2, 3, zero and the maximum 255;
    // idling: none, sender 55%, receiver 55%, both 18%, both 55%
    ph_div   = '{1,   3,   2,   0,   255, 255, 1};
    ph_poll  = '{0,   1,   0,   0,   1,   0,   1};
    ph_send  = '{0,   55,  0,   18,  0,   18,  55};
    ph_stall = '{0,   0,   55,  18,  0,   18,  55};
    ph_items = '{350, 300, 300, 300, 350, 250, 100};

    seq_reset();
    send_idle_pct = 0;
    stall_pct = 0;
    abort_xfer = 1'b0;
    requests_sent = 0;
    results_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    xfer_ok = 0;
    xfer_err = 0;
    rx_shown = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, field extremes, refusals and busy replies,
    // push into a running write, then the first steps of a repeated-start write.
    rows.push_back(mk_row(KIND_TICK,  1, 1, 8'h00, 7'h00, 8'd0,   0, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  0, 0, 8'hFF, 7'h7F, 8'd255, 1, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_PUSH,  0, 0, 8'hFF, 7'h00, 8'd0,   0, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_PUSH,  1, 1, 8'h00, 7'h7F, 8'd255, 1, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_PUSH,  0, 1, 8'h5A, 7'h2A, 8'd3,   0, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_WRITE, 0, 0, 8'h00, 7'h7F, 8'd17,  0, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_WRITE, 1, 1, 8'hFF, 7'h00, 8'd255, 1, 1, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_WRITE, 0, 0, 8'h00, 7'h7F, 8'd3,   1, 1, ST_OK,   ST_BUSY));
    rows.push_back(mk_row(KIND_READ,  0, 0, 8'h00, 7'h7F, 8'd255, 0, 1, ST_BUSY, ST_BUSY));
    rows.push_back(mk_row(KIND_READ,  1, 1, 8'hFF, 7'h00, 8'd0,   1, 1, ST_BUSY, ST_BUSY));
    rows.push_back(mk_row(KIND_WRITE, 0, 0, 8'h00, 7'h55, 8'd16,  0, 1, ST_BUSY, ST_BUSY));
    rows.push_back(mk_row(KIND_WRITE, 0, 0, 8'h00, 7'h55, 8'd0,   0, 1, ST_BUSY, ST_BUSY));
    rows.push_back(mk_row(KIND_PUSH,  0, 0, 8'h33, 7'h00, 8'd0,   0, 1, ST_ERR,  ST_BUSY));
    rows.push_back(mk_row(KIND_TICK,  1, 1, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  0, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  0, 1, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 1, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    rows.push_back(mk_row(KIND_TICK,  1, 0, 8'h00, 7'h00, 8'd0,   0, 0, ST_ERR,  ST_ERR));
    foreach (rows[i]) send_request(rows[i].it, rows[i].typed, rows[i].want);

    // Random phases; config only changes with the result channel empty.
    // A transfer may still be on the bus across a config change.
    budget = requests_sent;
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      repeat (6) @(posedge clk);
      apb_write(REG_STEP_DIVIDE, 32'(ph_div[p]));
      apb_write(REG_POLL_ALWAYS, 32'(ph_poll[p]));
      send_idle_pct = ph_send[p];
      stall_pct = ph_stall[p];
      budget += ph_items[p];
      while (requests_sent < budget) run_session();
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d results over %0d config phases, down to divide 0",
             requests_sent, results_seen, N_PHASES);
    $display("transfers: %0d ok, %0d ended in error; %0d read bytes presented",
             xfer_ok, xfer_err, rx_shown);
    if (mismatches == 0) $display("tb_i2c_master_bit_sequencer passed");
    else $display("tb_i2c_master_bit_sequencer failed");
    $finish;
  end

endmodule

[sim.f]
rtl/i2cbs_pkg.sv
rtl/i2cbs_ram.sv
rtl/i2cbs_prescale.sv
rtl/i2cbs_core.sv
rtl/i2c_master_bit_sequencer.sv
tb/sv/tb_i2c_master_bit_sequencer.sv
